[src/lbc_pkg.sv]
// Shared types and constants for the LRU block cache.
// No dependencies; used by every module under src.
`default_nettype none
package lbc_pkg;
   localparam int ENTRIES_DEF     = 512;
   localparam int KEY_BITS_DEF    = 48;
   localparam int HANDLE_BITS_DEF = 32;
   localparam int CAP_BITS        = 10;
   localparam int CAP_RESET       = 512;
   localparam int POS_BITS        = 12;

   typedef enum logic [1:0] {
      MODE_GET   = 2'd0,
      MODE_PUT   = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_NOP   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic                match_en;
      logic                shift;
      logic                clear;
      logic [POS_BITS-1:0] pos;
      logic [POS_BITS-1:0] tail;
   } ctl_type;
endpackage
`default_nettype wire

[src/lru_block_cache_top.sv]
// Top level of the LRU block cache: request control and the chain of cells.
// Depends on lbc_pkg and lbc_cell.
//
// Usage: items enter on req_ (mode, block_key, handle_in) with valid/ready and
// one result leaves per item on rsp_ (hit, handle_out, evicted, evicted_key).
// The csr_ port writes capacity; write it only while the cache is idle.
// Entries sit in a chain of cells ordered by recency, cell 0 most recent.
// An accepted item is compared in every cell in parallel in the match state;
// in the update state the hit position (for a put miss, the tail when full,
// else the first free cell) is encoded and, on a get hit or any put, the cells
// at or above it shift one place down the chain, the item's entry landing in
// cell 0. The result is registered at that edge, and the next item can be
// taken at that same edge. If rsp_ready is low with a result held, the
// update of the next item waits until the result register is free.
// Reset empties the cache and sets capacity to 512; no clearing pass.
`default_nettype none
module lru_block_cache_top #(
   parameter int ENTRIES     = lbc_pkg::ENTRIES_DEF,
   parameter int KEY_BITS    = lbc_pkg::KEY_BITS_DEF,
   parameter int HANDLE_BITS = lbc_pkg::HANDLE_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_mode,
   input  wire logic [KEY_BITS-1:0]           req_block_key,
   input  wire logic [HANDLE_BITS-1:0]        req_handle_in,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_hit,
   output logic [HANDLE_BITS-1:0]             rsp_handle_out,
   output logic                               rsp_evicted,
   output logic [KEY_BITS-1:0]                rsp_evicted_key,
   input  wire logic                          csr_write,
   input  wire logic [lbc_pkg::CAP_BITS-1:0]  csr_wdata
);
   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OW = $clog2(ENTRIES + 1);

   lbc_pkg::state_type state_ff, state_in;
   lbc_pkg::ctl_type   ctl;

   logic [lbc_pkg::CAP_BITS-1:0] cap_ff;
   logic [OW-1:0]                occ_ff, occ_in;
   lbc_pkg::mode_type            mode_ff;
   logic [KEY_BITS-1:0]          key_ff;
   logic [HANDLE_BITS-1:0]       hnd_ff;

   logic                         rsp_valid_ff, hit_ff, ev_ff;
   logic [HANDLE_BITS-1:0]       hout_ff;
   logic [KEY_BITS-1:0]          evkey_ff;

   logic                         slot_ok, accept, fire;
   logic                         any_hit, full, do_shift, load_rsp;
   logic [IW-1:0]                hit_pos;
   logic [HANDLE_BITS-1:0]       hit_handle, new_handle;
   logic [KEY_BITS-1:0]          tail_key;
   logic [31:0]                  eff_cap;
   logic                         r_hit, r_ev;
   logic [HANDLE_BITS-1:0]       r_hout;
   logic [KEY_BITS-1:0]          r_evkey;

   logic [ENTRIES:0]             c_valid;
   logic [KEY_BITS-1:0]          c_key    [ENTRIES+1];
   logic [HANDLE_BITS-1:0]       c_handle [ENTRIES+1];
   logic [ENTRIES-1:0]           c_match;
   logic [HANDLE_BITS-1:0]       c_mh     [ENTRIES];
   logic [KEY_BITS-1:0]          c_tk     [ENTRIES];

   assign slot_ok   = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == lbc_pkg::ST_IDLE) ||
                      (state_ff == lbc_pkg::ST_UPDATE && slot_ok);
   assign accept    = req_valid && req_ready;
   assign fire      = (state_ff == lbc_pkg::ST_UPDATE) && slot_ok;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lbc_pkg::ST_IDLE:   if (accept) state_in = lbc_pkg::ST_MATCH;
         lbc_pkg::ST_MATCH:  state_in = lbc_pkg::ST_UPDATE;
         lbc_pkg::ST_UPDATE: begin
            if (accept) state_in = lbc_pkg::ST_MATCH;
            else if (fire) state_in = lbc_pkg::ST_IDLE;
         end
         default: state_in = lbc_pkg::ST_IDLE;
      endcase
   end

   // hit position, hit handle and tail key reduced across the chain
   always_comb begin
      any_hit    = 1'b0;
      hit_pos    = '0;
      hit_handle = '0;
      tail_key   = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         any_hit    = any_hit | c_match[i];
         hit_pos    = hit_pos | (c_match[i] ? IW'(i) : '0);
         hit_handle = hit_handle | c_mh[i];
         tail_key   = tail_key | c_tk[i];
      end
   end

   always_comb begin
      eff_cap = 32'(cap_ff);
      if (eff_cap == 32'd0) eff_cap = 32'd1;
      if (eff_cap > 32'(ENTRIES)) eff_cap = 32'(ENTRIES);
   end
   assign full = 32'(occ_ff) >= eff_cap;

   always_comb begin
      ctl          = '0;
      ctl.match_en = (state_ff == lbc_pkg::ST_MATCH);
      ctl.tail     = lbc_pkg::POS_BITS'(occ_ff - OW'(1));
      do_shift     = 1'b0;
      occ_in       = occ_ff;
      new_handle   = hnd_ff;
      r_hit        = 1'b0;
      r_hout       = '0;
      r_ev         = 1'b0;
      r_evkey      = '0;
      case (mode_ff)
         lbc_pkg::MODE_GET: begin
            new_handle = hit_handle;
            if (any_hit) begin
               do_shift = 1'b1;
               ctl.pos  = lbc_pkg::POS_BITS'(hit_pos);
               r_hit    = 1'b1;
               r_hout   = hit_handle;
            end
         end
         lbc_pkg::MODE_PUT: begin
            do_shift = 1'b1;
            if (any_hit) begin
               ctl.pos = lbc_pkg::POS_BITS'(hit_pos);
               r_hit   = 1'b1;
            end else if (full) begin
               ctl.pos = lbc_pkg::POS_BITS'(occ_ff - OW'(1));
               r_ev    = 1'b1;
               r_evkey = tail_key;
            end else begin
               ctl.pos = lbc_pkg::POS_BITS'(occ_ff);
               occ_in  = occ_ff + OW'(1);
            end
         end
         lbc_pkg::MODE_CLEAR: begin
            ctl.clear = fire;
            occ_in    = '0;
         end
         default: ;
      endcase
      ctl.shift = fire && do_shift;
   end

   assign load_rsp = fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lbc_pkg::ST_IDLE;
         cap_ff       <= lbc_pkg::CAP_BITS'(lbc_pkg::CAP_RESET);
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write) cap_ff <= csr_wdata;
         if (fire) occ_ff <= occ_in;
         if (load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= lbc_pkg::mode_type'(req_mode);
         key_ff  <= req_block_key;
         hnd_ff  <= req_handle_in;
      end
      if (load_rsp) begin
         hit_ff   <= r_hit;
         hout_ff  <= r_hout;
         ev_ff    <= r_ev;
         evkey_ff <= r_evkey;
      end
   end

   assign c_valid[0]  = 1'b1;
   assign c_key[0]    = key_ff;
   assign c_handle[0] = new_handle;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      lbc_cell #(
         .KEY_BITS(KEY_BITS), .HANDLE_BITS(HANDLE_BITS), .IDX(g)
      ) u_cell (
         .clock(clock), .reset(reset), .ctl(ctl), .cmp_key(key_ff),
         .prev_valid(c_valid[g]), .prev_key(c_key[g]), .prev_handle(c_handle[g]),
         .valid_out(c_valid[g+1]), .key_out(c_key[g+1]),
         .handle_out(c_handle[g+1]), .match_out(c_match[g]),
         .match_handle(c_mh[g]), .tail_key(c_tk[g])
      );
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = hit_ff;
   assign rsp_handle_out  = hout_ff;
   assign rsp_evicted     = ev_ff;
   assign rsp_evicted_key = evkey_ff;
endmodule
`default_nettype wire

[src/lbc_cell.sv]
// One recency position of the LRU chain: entry storage, tag compare, shift.
// Depends on lbc_pkg.
`default_nettype none
module lbc_cell #(
   parameter int KEY_BITS    = lbc_pkg::KEY_BITS_DEF,
   parameter int HANDLE_BITS = lbc_pkg::HANDLE_BITS_DEF,
   parameter int IDX         = 0
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire lbc_pkg::ctl_type       ctl,
   input  wire logic [KEY_BITS-1:0]    cmp_key,
   input  wire logic                   prev_valid,
   input  wire logic [KEY_BITS-1:0]    prev_key,
   input  wire logic [HANDLE_BITS-1:0] prev_handle,
   output logic                        valid_out,
   output logic [KEY_BITS-1:0]         key_out,
   output logic [HANDLE_BITS-1:0]      handle_out,
   output logic                        match_out,
   output logic [HANDLE_BITS-1:0]      match_handle,
   output logic [KEY_BITS-1:0]         tail_key
);
   logic                   valid_ff, match_ff, take;
   logic [KEY_BITS-1:0]    key_ff;
   logic [HANDLE_BITS-1:0] handle_ff;

   assign take = ctl.shift && (lbc_pkg::POS_BITS'(IDX) <= ctl.pos);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         if (ctl.clear) valid_ff <= 1'b0;
         else if (take) valid_ff <= prev_valid;
         if (ctl.match_en) match_ff <= valid_ff && (key_ff == cmp_key);
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         key_ff    <= prev_key;
         handle_ff <= prev_handle;
      end
   end

   assign valid_out    = valid_ff;
   assign key_out      = key_ff;
   assign handle_out   = handle_ff;
   assign match_out    = match_ff;
   assign match_handle = match_ff ? handle_ff : '0;
   assign tail_key     = (valid_ff && lbc_pkg::POS_BITS'(IDX) == ctl.tail) ? key_ff : '0;
endmodule
`default_nettype wire

[src/lbc_checker.sv]
// Port-level checks for lru_block_cache_top, attached by bind.
// Depends on lbc_pkg and lru_block_cache_top.
`default_nettype none
module lbc_checker #(
   parameter int KEY_BITS    = lbc_pkg::KEY_BITS_DEF,
   parameter int HANDLE_BITS = lbc_pkg::HANDLE_BITS_DEF
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire logic                   rsp_hit,
   input wire logic [HANDLE_BITS-1:0] rsp_handle_out,
   input wire logic                   rsp_evicted,
   input wire logic [KEY_BITS-1:0]    rsp_evicted_key
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("item dropped while stalled");
   a_ev_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted |-> !rsp_hit)
      else $error("eviction on a hit");
   a_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_handle_out != '0 |-> rsp_hit && !rsp_evicted)
      else $error("handle without hit");
   a_evkey: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evicted |-> rsp_evicted_key == '0)
      else $error("evicted key without eviction");
endmodule

bind lru_block_cache_top lbc_checker #(
   .KEY_BITS(KEY_BITS), .HANDLE_BITS(HANDLE_BITS)
) u_lbc_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_hit(rsp_hit), .rsp_handle_out(rsp_handle_out),
   .rsp_evicted(rsp_evicted), .rsp_evicted_key(rsp_evicted_key)
);
`default_nettype wire

[sim/lru_block_cache_top_tb.sv]
// Testbench for lru_block_cache_top: drives get/put/clear/nop items, predicts
// each result with a recency-ordered list kept in the bench, checks every field.
// Depends on lbc_pkg and the RTL under src.
`default_nettype none
module lru_block_cache_top_tb;

   localparam int ENTRIES = 512;

   typedef struct packed {
      logic        hit;
      logic [31:0] handle_out;
      logic        evicted;
      logic [47:0] evicted_key;
   } result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_mode;
   logic [47:0] req_block_key;
   logic [31:0] req_handle_in;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_hit;
   logic [31:0] rsp_handle_out;
   logic        rsp_evicted;
   logic [47:0] rsp_evicted_key;
   logic        csr_write;
   logic [9:0]  csr_wdata;

   // recency list, index 0 most recent
   logic [47:0] lru_keys[$];
   logic [31:0] lru_handles[$];
   logic [9:0]  capacity_reg;

   result_type  pending_results[$];
   int          mismatch_count;
   int          items_sent;
   int          results_seen;
   int          evict_seen;
   int          hit_seen;
   int          burst_left;
   int          stall_phase;

   lru_block_cache_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_block_key(req_block_key), .req_handle_in(req_handle_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_hit(rsp_hit),
      .rsp_handle_out(rsp_handle_out), .rsp_evicted(rsp_evicted),
      .rsp_evicted_key(rsp_evicted_key),
      .csr_write(csr_write), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int cache_limit();
      int c;
      c = capacity_reg;
      if (c == 0) c = 1;
      if (c > ENTRIES) c = ENTRIES;
      return c;
   endfunction

   function automatic result_type predict_access(lbc_pkg::mode_type m, logic [47:0] k,
                                                  logic [31:0] h);
      result_type r;
      int pos;
      int last;
      logic [31:0] hv;
      r = '0;
      pos = -1;
      foreach (lru_keys[i]) if (pos < 0 && lru_keys[i] == k) pos = i;
      case (m)
         lbc_pkg::MODE_GET: begin
            if (pos >= 0) begin
               r.hit = 1'b1;
               hv = lru_handles[pos];
               r.handle_out = hv;
               lru_keys.delete(pos);
               lru_handles.delete(pos);
               lru_keys.insert(0, k);
               lru_handles.insert(0, hv);
            end
         end
         lbc_pkg::MODE_PUT: begin
            if (pos >= 0) begin
               r.hit = 1'b1;
               lru_keys.delete(pos);
               lru_handles.delete(pos);
            end else if (lru_keys.size() >= cache_limit() && lru_keys.size() > 0) begin
               last = lru_keys.size() - 1;
               r.evicted = 1'b1;
               r.evicted_key = lru_keys[last];
               lru_keys.delete(last);
               lru_handles.delete(last);
            end
            lru_keys.insert(0, k);
            lru_handles.insert(0, h);
         end
         lbc_pkg::MODE_CLEAR: begin
            lru_keys.delete();
            lru_handles.delete();
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_item(lbc_pkg::mode_type m, logic [47:0] k, logic [31:0] h);
      while (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(1, 40);
         end else begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            burst_left = $urandom_range(1, 12);
         end
      end
      burst_left--;
      pending_results.insert(pending_results.size(), predict_access(m, k, h));
      req_valid     <= 1'b1;
      req_mode      <= m;
      req_block_key <= k;
      req_handle_in <= h;
      items_sent++;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic set_capacity(logic [9:0] value);
      drain();
      csr_write    <= 1'b1;
      csr_wdata    <= value;
      capacity_reg = value;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // receiver stall pattern
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (stall_phase[9:7] == 3'd0) rsp_ready <= 1'b1;
      else if (stall_phase[9:7] == 3'd5) rsp_ready <= (stall_phase[3:0] == 4'd0);
      else rsp_ready <= ($urandom_range(0, 3) != 0);
   end

   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_hit, rsp_handle_out, rsp_evicted, rsp_evicted_key};
         results_seen++;
         if (rsp_hit) hit_seen++;
         if (rsp_evicted) evict_seen++;
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %h", got);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: hit %b/%b handle %h/%h evicted %b/%b key %h/%h",
                           want.hit, got.hit, want.handle_out, got.handle_out,
                           want.evicted, got.evicted, want.evicted_key, got.evicted_key);
            end
         end
      end
   end

   function automatic logic [47:0] rand_key();
      return 48'({$urandom(), $urandom()});
   endfunction

   task automatic test_directed();
      send_item(lbc_pkg::MODE_GET, 48'h0, 32'h0);
      send_item(lbc_pkg::MODE_PUT, 48'h0, 32'hFFFF_FFFF);
      send_item(lbc_pkg::MODE_PUT, 48'hFFFF_FFFF_FFFF, 32'h0);
      send_item(lbc_pkg::MODE_GET, 48'h0, 32'h1234);
      send_item(lbc_pkg::MODE_GET, 48'hFFFF_FFFF_FFFF, 32'h0);
      send_item(lbc_pkg::MODE_PUT, 48'h0, 32'hA5A5_5A5A);
      send_item(lbc_pkg::MODE_GET, 48'h0, 32'h0);
      send_item(lbc_pkg::MODE_NOP, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
      send_item(lbc_pkg::MODE_CLEAR, 48'h5555_5555_5555, 32'h5555_5555);
      send_item(lbc_pkg::MODE_GET, 48'h0, 32'h0);
   endtask

   task automatic test_capacity_one();
      set_capacity(10'd0);
      for (int i = 0; i < 6; i++) send_item(lbc_pkg::MODE_PUT, 48'(i), $urandom());
      send_item(lbc_pkg::MODE_GET, 48'd5, 32'h0);
      send_item(lbc_pkg::MODE_CLEAR, 48'h0, 32'h0);
      set_capacity(10'd1);
      send_item(lbc_pkg::MODE_PUT, 48'hAAAA_AAAA_AAAA, $urandom());
      send_item(lbc_pkg::MODE_PUT, 48'h5555_5555_5555, $urandom());
   endtask

   task automatic test_shrink_while_full();
      send_item(lbc_pkg::MODE_CLEAR, 48'h0, 32'h0);
      set_capacity(10'd8);
      for (int i = 0; i < 8; i++) send_item(lbc_pkg::MODE_PUT, 48'(100 + i), $urandom());
      set_capacity(10'd3);
      for (int i = 0; i < 4; i++) send_item(lbc_pkg::MODE_PUT, 48'(200 + i), $urandom());
      set_capacity(10'h3FF);
   endtask

   task automatic test_random(int count, int key_span);
      int m;
      logic [47:0] k;
      for (int i = 0; i < count; i++) begin
         m = $urandom_range(0, 99);
         if ($urandom_range(0, 9) == 0) k = rand_key();
         else k = 48'h8000_0000_0000 | 48'($urandom_range(0, key_span));
         if (m < 45) send_item(lbc_pkg::MODE_GET, k, $urandom());
         else if (m < 95) send_item(lbc_pkg::MODE_PUT, k, $urandom());
         else if (m < 97) send_item(lbc_pkg::MODE_NOP, k, $urandom());
         else send_item(lbc_pkg::MODE_CLEAR, k, $urandom());
      end
   endtask

   task automatic test_full_capacity();
      send_item(lbc_pkg::MODE_CLEAR, 48'h0, 32'h0);
      set_capacity(10'd512);
      for (int i = 0; i < 515; i++) send_item(lbc_pkg::MODE_PUT, 48'(1000 + i), $urandom());
      send_item(lbc_pkg::MODE_GET, 48'd1003, 32'h0);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0; req_mode = lbc_pkg::MODE_GET; req_block_key = '0;
      req_handle_in = '0;
      rsp_ready = 1'b0; csr_write = 1'b0; csr_wdata = '0;
      capacity_reg = 10'd512;
      mismatch_count = 0; items_sent = 0; results_seen = 0;
      evict_seen = 0; hit_seen = 0; burst_left = 0; stall_phase = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_capacity_one();
      test_shrink_while_full();
      send_item(lbc_pkg::MODE_CLEAR, 48'h0, 32'h0);
      set_capacity(10'd4);
      test_random(250, 12);
      send_item(lbc_pkg::MODE_CLEAR, 48'h0, 32'h0);
      set_capacity(10'd16);
      test_random(250, 40);
      send_item(lbc_pkg::MODE_CLEAR, 48'h0, 32'h0);
      set_capacity(10'd2);
      test_random(150, 6);
      test_full_capacity();
      drain();
      $display("%0d items sent, %0d results checked (%0d hits, %0d evictions)",
               items_sent, results_seen, hit_seen, evict_seen);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #4000000;
      $display("status: fail");
      $finish;
   end
endmodule
`default_nettype wire

[sim.f]
src/lbc_pkg.sv
src/lbc_cell.sv
src/lru_block_cache_top.sv
src/lbc_checker.sv
sim/lru_block_cache_top_tb.sv
